/* hdl/rmfr_pkg.sv */
// Shared types and constants for the repeated-marker frame receiver.
// No dependencies; imported by every module of the block but rmfr_in_reg.
package rmfr_pkg;

  // Largest payload size the block will ever accept, whatever max_payload says
  localparam logic [31:0] PAYLOAD_LIMIT = 32'd65535;

  // Frame layout
  localparam logic [7:0]  MARKER_MIN    = 8'h81;
  localparam logic [31:0] CHECK_SEED    = 32'h5555_5555;
  localparam logic [15:0] SIZE_SAT      = 16'hFFFF;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BADCHK = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  // One result transaction
  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic        data_valid;
    logic [6:0]  command;
    logic [15:0] size;
    logic        last;
  } result_t;

endpackage

/* hdl/rmfr_in_reg.sv */
// Input register stage: captures one received byte per transaction.
// No package dependencies; feeds rmfr_frame_fsm through the top level.
module rmfr_in_reg
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] rx_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;

  // Free when empty or when the held byte moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_valid = valid_r;
  assign rx_byte    = byte_r;

endmodule

/* hdl/rmfr_frame_fsm.sv */
// Frame tracking state: marker hunt, header capture, payload and verdict.
// Depends on rmfr_pkg for status codes, the result struct and constants.
module rmfr_frame_fsm
  import rmfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_payload,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t      phase_r,       phase_nxt;
  logic [7:0]  marker_byte_r, marker_byte_nxt;
  logic [2:0]  marker_cnt_r,  marker_cnt_nxt;
  logic [2:0]  hdr_idx_r,     hdr_idx_nxt;
  logic [31:0] size_word_r,   size_word_nxt;
  logic [31:0] check_word_r,  check_word_nxt;
  logic [7:0]  run_xor_r,     run_xor_nxt;
  logic [15:0] pay_cnt_r,     pay_cnt_nxt;

  logic [31:0] limit;
  logic [31:0] res_size_word;

  // Effective limit is the smaller of the register and the hard cap
  assign limit = ({16'd0, max_payload} < PAYLOAD_LIMIT) ? {16'd0, max_payload}
                                                        : PAYLOAD_LIMIT;

  // Check word compared in full against the seed with the payload XOR folded in
  function automatic status_t check_verdict(input logic [31:0] chk, input logic [7:0] x);
    return (chk == (CHECK_SEED ^ {24'd0, x})) ? ST_GOOD : ST_BADCHK;
  endfunction

  always_comb begin
    phase_nxt       = phase_r;
    marker_byte_nxt = marker_byte_r;
    marker_cnt_nxt  = marker_cnt_r;
    hdr_idx_nxt     = hdr_idx_r;
    size_word_nxt   = size_word_r;
    check_word_nxt  = check_word_r;
    run_xor_nxt     = run_xor_r;
    pay_cnt_nxt     = pay_cnt_r;
    res_size_word   = size_word_r;

    res_valid       = 1'b0;
    res.status      = ST_BUSY;
    res.data        = 8'd0;
    res.data_valid  = 1'b0;
    res.last        = 1'b0;

    case (phase_r)
      // Header: four size bytes then four check bytes, little-endian
      PH_HEADER: begin
        hdr_idx_nxt = hdr_idx_r + 3'd1;
        if (!hdr_idx_r[2]) begin
          size_word_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = rx_byte;
        end else begin
          check_word_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = rx_byte;
        end
        res_size_word = size_word_nxt;
        if (&hdr_idx_r) begin
          if (size_word_nxt > limit) begin
            res_valid      = 1'b1;
            res.status     = ST_OVER;
            res.last       = 1'b1;
            phase_nxt      = PH_HUNT;
            marker_cnt_nxt = 3'd0;
            hdr_idx_nxt    = 3'd0;
          end else begin
            run_xor_nxt = 8'd0;
            pay_cnt_nxt = 16'd0;
            if (size_word_nxt == 32'd0) begin
              // Empty payload: verdict on the last header byte
              res_valid      = 1'b1;
              res.status     = check_verdict(check_word_nxt, 8'd0);
              res.last       = 1'b1;
              phase_nxt      = PH_HUNT;
              marker_cnt_nxt = 3'd0;
              hdr_idx_nxt    = 3'd0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end

      // Payload: stream each byte, verdict rides on the final one
      PH_PAYLOAD: begin
        run_xor_nxt    = run_xor_r ^ rx_byte;
        pay_cnt_nxt    = pay_cnt_r + 16'd1;
        res_valid      = 1'b1;
        res.data       = rx_byte;
        res.data_valid = 1'b1;
        if ({16'd0, pay_cnt_nxt} >= size_word_r) begin
          res.status     = check_verdict(check_word_r, run_xor_nxt);
          res.last       = 1'b1;
          phase_nxt      = PH_HUNT;
          marker_cnt_nxt = 3'd0;
          hdr_idx_nxt    = 3'd0;
        end
      end

      // Hunt for eight equal marker bytes
      default: begin
        phase_nxt = PH_HUNT;
        if ((marker_cnt_r != 3'd0) && (rx_byte == marker_byte_r)) begin
          marker_cnt_nxt = marker_cnt_r + 3'd1;
          if (&marker_cnt_r) begin
            marker_cnt_nxt = 3'd0;
            hdr_idx_nxt    = 3'd0;
            size_word_nxt  = 32'd0;
            check_word_nxt = 32'd0;
            phase_nxt      = PH_HEADER;
          end
        end else if (rx_byte >= MARKER_MIN) begin
          marker_byte_nxt = rx_byte;
          marker_cnt_nxt  = 3'd1;
        end else begin
          marker_cnt_nxt = 3'd0;
        end
      end
    endcase

    // Command is the marker byte less 128; size saturates at 16 bits
    res.command = marker_byte_r[6:0];
    res.size    = (|res_size_word[31:16]) ? SIZE_SAT : res_size_word[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      marker_byte_r <= 8'd0;
      marker_cnt_r  <= 3'd0;
      hdr_idx_r     <= 3'd0;
      size_word_r   <= 32'd0;
      check_word_r  <= 32'd0;
      run_xor_r     <= 8'd0;
      pay_cnt_r     <= 16'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      marker_byte_r <= marker_byte_nxt;
      marker_cnt_r  <= marker_cnt_nxt;
      hdr_idx_r     <= hdr_idx_nxt;
      size_word_r   <= size_word_nxt;
      check_word_r  <= check_word_nxt;
      run_xor_r     <= run_xor_nxt;
      pay_cnt_r     <= pay_cnt_nxt;
    end
  end

endmodule

/* hdl/rmfr_out_reg.sv */
// Result register: holds one result transaction until the consumer takes it.
// Depends on rmfr_pkg for the result struct.
module rmfr_out_reg
  import rmfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r,   res_nxt;

  // A new result may enter when empty or when the held one leaves now
  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* hdl/repeated_marker_frame_receiver_unit.sv */
// Repeated-marker frame receiver, top level. Takes one received byte per
// transaction and accepts a new byte every cycle while results keep flowing;
// a byte passes through an input register and a result register before its
// result appears. The frame state update between those registers sets the
// one-byte-per-cycle figure. A frame is eight equal marker bytes of 0x81 or
// above, a little-endian 32-bit size and check word, then the payload; every
// payload byte is a result and the last result of a frame carries the verdict.
// max_payload is written through the cfg port, always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// Depends on rmfr_pkg, rmfr_in_reg, rmfr_frame_fsm and rmfr_out_reg.
module repeated_marker_frame_receiver_unit
  import rmfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_payload,
  output logic        out_payload_valid,
  output logic [6:0]  out_command,
  output logic [15:0] out_frame_size,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_payload
);

  logic        byte_valid;
  logic [7:0]  rx_byte;
  logic        space;
  logic        step;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic [15:0] max_payload_r;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // A byte is processed once the result register can take its outcome
  assign step = byte_valid && space;

  rmfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (step),
    .byte_valid (byte_valid),
    .rx_byte    (rx_byte)
  );

  rmfr_frame_fsm u_frame_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (rx_byte),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  rmfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Result fields
  assign out_status        = out_res.status;
  assign out_payload       = out_res.data;
  assign out_payload_valid = out_res.data_valid;
  assign out_command       = out_res.command;
  assign out_frame_size    = out_res.size;
  assign out_last          = out_res.last;

endmodule

/* tb/sv/rmfr_frame_checker.sv */
// Frame checker for the repeated-marker frame receiver: tracks the byte
// stream, predicts every result transaction and compares what comes out.
// Depends on rmfr_pkg for the status codes and the result layout.
module rmfr_frame_checker
  import rmfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_payload,
  input  logic        out_payload_valid,
  input  logic [6:0]  out_command,
  input  logic [15:0] out_frame_size,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_max_payload,
  output int          fail_count,
  output int          pending
);

  localparam int MARKER_RUN   = 8;
  localparam int HEADER_BYTES = 8;
  localparam int PRINT_CAP    = 100;

  typedef enum logic [1:0] {
    HUNT    = 2'd0,
    HEADER  = 2'd1,
    PAYLOAD = 2'd2
  } rx_phase_t;

  // Shadow of the receiver state
  rx_phase_t   phase;
  logic [7:0]  marker_byte;
  int          marker_count;
  int          header_index;
  logic [31:0] size_word;
  logic [31:0] check_word;
  logic [7:0]  running_xor;
  logic [15:0] payload_count;
  logic [15:0] max_payload;

  // Results still owed by the block, oldest first
  result_t frame_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endtask

  function automatic status_t frame_verdict();
    return (check_word == (CHECK_SEED ^ {24'd0, running_xor})) ? ST_GOOD : ST_BADCHK;
  endfunction

  task automatic queue_result(input status_t st, input logic [7:0] d, input logic dv,
                              input logic lst);
    result_t r;
    r.status     = st;
    r.data       = d;
    r.data_valid = dv;
    r.command    = 7'(marker_byte - 8'd128);
    r.size       = (size_word > {16'd0, SIZE_SAT}) ? SIZE_SAT : size_word[15:0];
    r.last       = lst;
    frame_results.push_back(r);
  endtask

  task automatic restart_hunt();
    phase        = HUNT;
    marker_count = 0;
    header_index = 0;
  endtask

  // Advance the shadow state by one received byte
  task automatic track_frame_byte(input logic [7:0] b);
    logic [31:0] limit;
    int          sh;
    case (phase)
      HEADER: begin
        sh = (header_index % 4) * 8;
        if (header_index < 4) size_word[sh +: 8] = b;
        else                  check_word[sh +: 8] = b;
        header_index++;
        if (header_index == HEADER_BYTES) begin
          limit = {16'd0, max_payload};
          if (PAYLOAD_LIMIT < limit) limit = PAYLOAD_LIMIT;
          if (size_word > limit) begin
            queue_result(ST_OVER, 8'd0, 1'b0, 1'b1);
            restart_hunt();
          end else begin
            running_xor   = 8'd0;
            payload_count = 16'd0;
            // empty payload: verdict comes on the last header byte
            if (size_word == 32'd0) begin
              queue_result(frame_verdict(), 8'd0, 1'b0, 1'b1);
              restart_hunt();
            end else begin
              phase = PAYLOAD;
            end
          end
        end
      end
      PAYLOAD: begin
        running_xor   = running_xor ^ b;
        payload_count = payload_count + 16'd1;
        if ({16'd0, payload_count} >= size_word) begin
          queue_result(frame_verdict(), b, 1'b1, 1'b1);
          restart_hunt();
        end else begin
          queue_result(ST_BUSY, b, 1'b1, 1'b0);
        end
      end
      default: begin
        phase = HUNT;
        if (marker_count != 0 && b == marker_byte) begin
          marker_count++;
          if (marker_count >= MARKER_RUN) begin
            marker_count = 0;
            header_index = 0;
            size_word    = 32'd0;
            check_word   = 32'd0;
            phase        = HEADER;
          end
        end else if (b >= MARKER_MIN) begin
          // a high byte breaking the run starts a fresh one; 0x80 never does
          marker_byte  = b;
          marker_count = 1;
        end else begin
          marker_count = 0;
        end
      end
    endcase
  endtask

  // Compare one accepted result transaction with the oldest prediction
  task automatic check_result();
    result_t want;
    if (frame_results.size() == 0) begin
      report_mismatch("result with no byte awaiting one", 0, out_status);
      return;
    end
    want = frame_results.pop_front();
    if (out_status != want.status)         report_mismatch("status", want.status, out_status);
    if (out_payload != want.data)          report_mismatch("data", want.data, out_payload);
    if (out_payload_valid != want.data_valid)
      report_mismatch("data_valid", want.data_valid, out_payload_valid);
    if (out_command != want.command)       report_mismatch("command", want.command, out_command);
    if (out_frame_size != want.size)       report_mismatch("size", want.size, out_frame_size);
    if (out_last != want.last)             report_mismatch("last", want.last, out_last);
  endtask

  // Channel monitor: results are compared before the new byte is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      phase         = HUNT;
      marker_byte   = 8'd0;
      marker_count  = 0;
      header_index  = 0;
      size_word     = 32'd0;
      check_word    = 32'd0;
      running_xor   = 8'd0;
      payload_count = 16'd0;
      max_payload   = SIZE_SAT;
      frame_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_payload = cfg_max_payload;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready)   track_frame_byte(in_rx_byte);
    end
    pending <= frame_results.size();
  end

endmodule

/* tb/sv/repeated_marker_frame_receiver_unit_tb.sv */
// Top of the frame receiver testbench: clock, reset, byte and config stimulus,
// a stalling result sink and the verdict. Depends on rmfr_pkg, the block
// repeated_marker_frame_receiver_unit and rmfr_frame_checker.
module repeated_marker_frame_receiver_unit_tb
  import rmfr_pkg::*;
();

  localparam int RANDOM_BYTES = 300;
  localparam int SETTLE       = 6;

  typedef enum logic [1:0] {
    RDY_ALWAYS   = 2'd0,
    RDY_COIN     = 2'd1,
    RDY_SPARSE   = 2'd2,
    RDY_PERIODIC = 2'd3
  } ready_mode_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic [7:0]  in_rx_byte      = 8'd0;
  logic        out_ready       = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic [15:0] cfg_max_payload = 16'd0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_payload;
  logic        out_payload_valid;
  logic [6:0]  out_command;
  logic [15:0] out_frame_size;
  logic        out_last;
  logic        cfg_ready;
  int          fail_count;
  int          pending;

  // Sender bookkeeping
  int          burst_left = 0;
  int          sent_bytes = 0;
  logic [15:0] max_now    = SIZE_SAT;

  // Sink bookkeeping
  ready_mode_t rdy_mode   = RDY_ALWAYS;
  int          rdy_left   = 0;
  int          tick       = 0;

  always #2 clk = ~clk;

  repeated_marker_frame_receiver_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_payload       (out_payload),
    .out_payload_valid (out_payload_valid),
    .out_command       (out_command),
    .out_frame_size    (out_frame_size),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_payload   (cfg_max_payload)
  );

  rmfr_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_payload       (out_payload),
    .out_payload_valid (out_payload_valid),
    .out_command       (out_command),
    .out_frame_size    (out_frame_size),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_payload   (cfg_max_payload),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Result sink: ready pattern is picked at random among always, coin, sparse and periodic
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = ready_mode_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(20, 200);
    end
    rdy_left--;
    tick++;
    case (rdy_mode)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= (tick % 3 != 0);
    endcase
  end

  // One byte transaction; bursts of random length separated by idle gaps
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_bytes++;
  endtask

  // Stop sending, wait for every owed result, then let the block settle
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [15:0] v);
    drain();
    cfg_valid       <= 1'b1;
    cfg_max_payload <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_now = v;
  endtask

  // Marker run, size and check word little-endian, then the payload.
  // fill < 0 gives random payload bytes; chk_flip corrupts the check word.
  task automatic send_frame(input logic [7:0] marker, input logic [31:0] size_field,
                            input int n_payload, input logic [31:0] chk_flip,
                            input int fill);
    logic [7:0]  body[$];
    logic [7:0]  x;
    logic [31:0] chk;
    x = 8'd0;
    for (int i = 0; i < n_payload; i++) begin
      body.push_back((fill < 0) ? 8'($urandom) : fill[7:0]);
      x = x ^ body[i];
    end
    chk = CHECK_SEED ^ {24'd0, x} ^ chk_flip;
    repeat (8) send_byte(marker);
    for (int i = 0; i < 4; i++) send_byte(size_field[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(chk[8*i +: 8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Mostly well-formed frames with random content, some bad or broken
  task automatic run_random_phase(input int n_bytes);
    int          stop_at;
    int          pick;
    int          plen;
    int          k;
    logic [7:0]  mark;
    logic [7:0]  alt;
    logic [31:0] flip;
    logic [31:0] sizef;
    stop_at = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      mark = 8'($urandom_range(129, 255));
      plen = $urandom_range(0, (max_now < 12) ? max_now : 12);
      if (max_now >= 40 && $urandom_range(0, 19) == 0) plen = $urandom_range(13, 40);
      if (pick < 65) begin
        send_frame(mark, plen, plen, 32'd0, -1);
      end else if (pick < 77) begin
        // corrupt either the low byte or only the upper bytes of the check word
        flip = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(1, 255))
                                           : 32'($urandom_range(1, 24'hFF_FFFF)) << 8;
        send_frame(mark, plen, plen, flip, -1);
      end else if (pick < 85) begin
        sizef = {16'd0, max_now} + 32'($urandom_range(1, 4));
        if (max_now == SIZE_SAT || $urandom_range(0, 1) == 1)
          sizef = $urandom | 32'h0001_0000;
        send_frame(mark, sizef, 0, 32'd0, -1);
      end else if (pick < 93) begin
        // short or ignored run ahead of the real marker
        alt = ($urandom_range(0, 3) == 0) ? 8'h80 : {1'b1, 7'($urandom)};
        if (alt == mark) alt = mark ^ 8'h01;
        k = (alt == 8'h80) ? $urandom_range(1, 12) : $urandom_range(1, 7);
        repeat (k) send_byte(alt);
        if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 128)));
        send_frame(mark, plen, plen, 32'd0, -1);
      end else begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
        send_byte(8'h00);
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  // Run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of marker, payload and check word at the widest limit
    set_max_payload(SIZE_SAT);
    send_frame(8'hFF, 32'd0, 0, 32'd0, 0);
    send_frame(8'h81, 32'd1, 1, 32'd0, 8'h00);
    send_frame(8'hC0, 32'd2, 2, 32'h0000_0001, 8'hFF);
    send_frame(8'h90, 32'd0, 0, 32'h8000_0000, 0);
    send_frame(8'hA5, 32'h0001_0000, 0, 32'd0, 0);
    send_frame(8'hDE, 32'hFFFF_FFFF, 0, 32'd0, 0);
    // 0x80 runs are ignored; a run broken by another high byte restarts
    repeat (9) send_byte(8'h80);
    send_byte(8'h00);
    repeat (4) send_byte(8'hB1);
    send_frame(8'hB2, 32'd1, 1, 32'd0, 8'h5A);
    repeat (5) send_byte(8'hB3);
    send_byte(8'h7F);
    send_frame(8'hB3, 32'd1, 1, 32'd0, -1);
    repeat (3) send_byte(8'hE0);
    send_byte(8'h80);
    send_frame(8'hE0, 32'd2, 2, 32'd0, -1);

    // Directed: smallest limit, then a limit of three
    set_max_payload(16'd0);
    send_frame(8'h82, 32'd0, 0, 32'd0, 0);
    send_frame(8'h83, 32'd1, 0, 32'd0, 0);
    set_max_payload(16'd3);
    send_frame(8'h84, 32'd3, 3, 32'd0, -1);
    send_frame(8'h85, 32'd4, 0, 32'd0, 0);

    // Random phases across several limits
    set_max_payload(SIZE_SAT);
    run_random_phase(RANDOM_BYTES / 5);
    set_max_payload(16'd0);
    run_random_phase(RANDOM_BYTES / 5);
    set_max_payload(16'($urandom_range(1, 15)));
    run_random_phase(RANDOM_BYTES / 5);
    set_max_payload(16'($urandom_range(16, 65534)));
    run_random_phase(RANDOM_BYTES / 5);
    set_max_payload(SIZE_SAT);
    run_random_phase(RANDOM_BYTES / 5);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
